// File: design/mbc_pkg.sv
// Shared constants for the Mur boundary cell update block.
// Depends on nothing; used by the interfaces and the top level.
`timescale 1ns / 1ps

package mbc_pkg;

  // Fixed field widths of the permittivity and Courant inputs.
  localparam int EPS_BITS     = 24;
  localparam int COURANT_BITS = 18;

  // Register map of the configuration port.
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic {
    REG_COURANT_X = 1'b0,
    REG_COURANT_Y = 1'b1
  } reg_idx_t;

  // Reset value of both Courant numbers (0.5 in Q2.16).
  localparam logic [COURANT_BITS-1:0] COURANT_RESET = COURANT_BITS'(32768);

endpackage

// File: design/mbc_if.sv
// Valid/ready channel interfaces for input and result beats.
// Depends on mbc_pkg for the permittivity width.
`timescale 1ns / 1ps

interface mbc_in_if #(parameter int FIELD_BITS = 32) ();
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [mbc_pkg::EPS_BITS-1:0]      eps_inner;
  logic signed [FIELD_BITS-1:0]      ez_inner;
  logic signed [FIELD_BITS-1:0]      old_inner;
  logic signed [FIELD_BITS-1:0]      old_edge;

  modport source (output valid, op, eps_inner, ez_inner, old_inner, old_edge,
                  input ready);
  modport sink   (input valid, op, eps_inner, ez_inner, old_inner, old_edge,
                  output ready);
endinterface

interface mbc_out_if #(parameter int FIELD_BITS = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] ez_edge;

  modport source (output valid, ez_edge, input ready);
  modport sink   (input valid, ez_edge, output ready);
endinterface

// File: design/mur_boundary_cell_update.sv
// Top level of the Mur first-order absorbing boundary cell update.
// Depends on mbc_pkg and the channel interfaces in mbc_if.sv.
`timescale 1ns / 1ps

// Usage
// The input channel carries one boundary cell per beat: the edge kind (op),
// the inner neighbour's permittivity and the three field samples. The result
// channel returns one beat with the new, saturated edge field for each input
// beat, in order. courant_x (address 0) and courant_y (address 4) are to be
// set through the APB port only while no cell is in flight (the block does
// not enforce this); pready is tied high. One cell per clock is taken while
// no result is held. Stages: the square root recurrence (one result bit per
// stage), the Courant divide and the coefficient divide (one quotient bit per
// stage each), plus six for entry, the Courant divide load, coefficient
// set-up, multiply, round and saturate; 20 + 34 + 36 + 6 = 96 by default.
// Reset empties the pipeline and loads both Courant numbers with 0.5.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ch.ready drops in the same cycle; nothing is lost or repeated.
module mur_boundary_cell_update #(
  parameter int FIELD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mbc_in_if.sink                               in_ch,
  mbc_out_if.source                            out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mbc_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [mbc_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [mbc_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);

  localparam int CB     = mbc_pkg::COURANT_BITS;
  localparam int EB     = mbc_pkg::EPS_BITS;
  localparam int FB     = FIELD_BITS;
  localparam int F      = FRAC_BITS;
  // Clamped permittivity width, square root input and recurrence sizes.
  localparam int E_W    = (EB > F) ? EB : F + 1;
  localparam int SQ_IN  = E_W + F;
  localparam int SQ_ST  = (SQ_IN + 1) / 2;
  localparam int SQ_X   = 2 * SQ_ST;
  localparam int SQ_R   = SQ_ST + 3;
  // Courant divide: numerator courant << F, quotient below 2^CB.
  localparam int N1     = CB + F;
  localparam int DR1    = SQ_ST + 1;
  // Coefficient divide.
  localparam int D_W    = ((CB > F) ? CB : F) + 1;
  localparam int N2     = D_W + F + 1;
  localparam int DR2    = D_W + 1;
  localparam int KW     = F + 1;
  // Multiply, round and saturate.
  localparam int DM_W   = FB + 1;
  localparam int H      = DM_W / 2;
  localparam int PL_W   = KW + H;
  localparam int PH_W   = KW + DM_W - H;
  localparam int P_W    = KW + DM_W + 1;
  localparam int T_W    = P_W - F;
  localparam int SW     = T_W + 2;

  typedef struct packed {
    logic [CB-1:0]          courant;
    logic                   dneg;
    logic [DM_W-1:0]        dmag;
    logic signed [FB-1:0]   oi;
  } carry_t;

  logic en;

  // ---------------------------------------------------------------------
  // Configuration registers.
  logic [CB-1:0] courant_x_r, courant_y_r;
  logic          cfg_wr;
  logic          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      courant_x_r <= mbc_pkg::COURANT_RESET;
      courant_y_r <= mbc_pkg::COURANT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mbc_pkg::REG_COURANT_X: courant_x_r <= pwdata[CB-1:0];
        mbc_pkg::REG_COURANT_Y: courant_y_r <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      mbc_pkg::REG_COURANT_X: prdata = mbc_pkg::CFG_DATA_BITS'(courant_x_r);
      mbc_pkg::REG_COURANT_Y: prdata = mbc_pkg::CFG_DATA_BITS'(courant_y_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves unless a result is held.
  logic out_valid_r;
  logic signed [FB-1:0] out_data_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------------------------------------------------------------
  // Entry: clamp permittivity, form the field difference.
  logic [E_W-1:0]  eps_w, one_e, eps_c;
  logic signed [FB:0] diff;
  carry_t          entry_c;

  always_comb begin
    eps_w = E_W'(in_ch.eps_inner);
    one_e = E_W'(1) << F;
    eps_c = (eps_w < one_e) ? one_e : eps_w;
    diff  = (FB+1)'(in_ch.ez_inner) - (FB+1)'(in_ch.old_edge);
    diff  = $signed({in_ch.ez_inner[FB-1], in_ch.ez_inner})
          - $signed({in_ch.old_edge[FB-1], in_ch.old_edge});
    entry_c.courant = in_ch.op ? courant_x_r : courant_y_r;
    entry_c.dneg    = diff[FB];
    entry_c.dmag    = diff[FB] ? DM_W'(-diff) : DM_W'(diff);
    entry_c.oi      = in_ch.old_inner;
  end

  // ---------------------------------------------------------------------
  // Square root, two radicand bits per stage.
  logic              sq_v   [0:SQ_ST];
  logic [SQ_X-1:0]   sq_x   [0:SQ_ST];
  logic [SQ_ST-1:0]  sq_root[0:SQ_ST];
  logic [SQ_R-1:0]   sq_rem [0:SQ_ST];
  carry_t            sq_c   [0:SQ_ST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0]    <= SQ_X'(eps_c) << F;
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
      sq_c[0]    <= entry_c;
    end
  end

  for (genvar i = 0; i < SQ_ST; i++) begin : g_sqrt
    logic [SQ_R-1:0] rem_sh, trial;
    logic            take;

    always_comb begin
      rem_sh = {sq_rem[i][SQ_R-3:0], sq_x[i][SQ_X-1 -: 2]};
      trial  = SQ_R'({sq_root[i], 2'b01});
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v[i+1] <= 1'b0;
      end else if (en) begin
        sq_v[i+1] <= sq_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x[i+1]    <= sq_x[i] << 2;
        sq_root[i+1] <= {sq_root[i][SQ_ST-2:0], take};
        sq_rem[i+1]  <= take ? rem_sh - trial : rem_sh;
        sq_c[i+1]    <= sq_c[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Courant divide: s = (courant << F) / sqrt(eps), one bit per stage.
  logic              d1_v  [0:N1];
  logic [N1-1:0]     d1_q  [0:N1];
  logic [DR1-1:0]    d1_rem[0:N1];
  logic [SQ_ST-1:0]  d1_d  [0:N1];
  carry_t            d1_c  [0:N1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v[0] <= 1'b0;
    end else if (en) begin
      d1_v[0] <= sq_v[SQ_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_q[0]   <= N1'(sq_c[SQ_ST].courant) << F;
      d1_rem[0] <= '0;
      d1_d[0]   <= sq_root[SQ_ST];
      d1_c[0]   <= sq_c[SQ_ST];
    end
  end

  for (genvar i = 0; i < N1; i++) begin : g_div1
    logic [DR1-1:0] rem_sh, dv;
    logic           take;

    always_comb begin
      rem_sh = {d1_rem[i][DR1-2:0], d1_q[i][N1-1]};
      dv     = DR1'(d1_d[i]);
      take   = rem_sh >= dv;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v[i+1] <= 1'b0;
      end else if (en) begin
        d1_v[i+1] <= d1_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d1_q[i+1]   <= {d1_q[i][N1-2:0], take};
        d1_rem[i+1] <= take ? rem_sh - dv : rem_sh;
        d1_d[i+1]   <= d1_d[i];
        d1_c[i+1]   <= d1_c[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Coefficient set-up: numerator and denominator of (s - 1) / (s + 1).
  logic [D_W-1:0] s_w, one_d, num_w, den_w;
  logic           kneg_w;

  always_comb begin
    s_w    = D_W'(d1_q[N1][CB-1:0]);
    one_d  = D_W'(1) << F;
    kneg_w = s_w < one_d;
    num_w  = kneg_w ? one_d - s_w : s_w - one_d;
    den_w  = s_w + one_d;
  end

  logic              d2_v   [0:N2];
  logic [N2-1:0]     d2_q   [0:N2];
  logic [DR2-1:0]    d2_rem [0:N2];
  logic [D_W-1:0]    d2_d   [0:N2];
  logic              d2_kneg[0:N2];
  carry_t            d2_c   [0:N2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v[0] <= 1'b0;
    end else if (en) begin
      d2_v[0] <= d1_v[N1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_q[0]    <= (N2'(num_w) << F) + N2'(den_w >> 1);
      d2_rem[0]  <= '0;
      d2_d[0]    <= den_w;
      d2_kneg[0] <= kneg_w;
      d2_c[0]    <= d1_c[N1];
    end
  end

  // Coefficient divide, one bit per stage, rounded by the half added above.
  for (genvar i = 0; i < N2; i++) begin : g_div2
    logic [DR2-1:0] rem_sh, dv;
    logic           take;

    always_comb begin
      rem_sh = {d2_rem[i][DR2-2:0], d2_q[i][N2-1]};
      dv     = DR2'(d2_d[i]);
      take   = rem_sh >= dv;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v[i+1] <= 1'b0;
      end else if (en) begin
        d2_v[i+1] <= d2_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2_q[i+1]    <= {d2_q[i][N2-2:0], take};
        d2_rem[i+1]  <= take ? rem_sh - dv : rem_sh;
        d2_d[i+1]    <= d2_d[i];
        d2_kneg[i+1] <= d2_kneg[i];
        d2_c[i+1]    <= d2_c[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Multiply: two partial products of the coefficient and the difference.
  logic [KW-1:0]        kmag;
  logic                 m1_v_r;
  logic [PL_W-1:0]      m1_plo_r;
  logic [PH_W-1:0]      m1_phi_r;
  logic                 m1_neg_r;
  logic signed [FB-1:0] m1_oi_r;

  assign kmag = d2_q[N2][KW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= d2_v[N2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_plo_r <= PL_W'(kmag) * PL_W'(d2_c[N2].dmag[H-1:0]);
      m1_phi_r <= PH_W'(kmag) * PH_W'(d2_c[N2].dmag[DM_W-1:H]);
      m1_neg_r <= d2_kneg[N2] ^ d2_c[N2].dneg;
      m1_oi_r  <= d2_c[N2].oi;
    end
  end

  // Combine the partial products, round half away from zero, drop F bits.
  logic [P_W-1:0]       prod;
  logic                 m2_v_r;
  logic [T_W-1:0]       m2_term_r;
  logic                 m2_neg_r;
  logic signed [FB-1:0] m2_oi_r;

  assign prod = P_W'(m1_plo_r) + (P_W'(m1_phi_r) << H) + (P_W'(1) << (F - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_term_r <= prod[P_W-1:F];
      m2_neg_r  <= m1_neg_r;
      m2_oi_r   <= m1_oi_r;
    end
  end

  // ---------------------------------------------------------------------
  // Add to the old inner field and saturate into the output register.
  logic signed [SW-1:0] oi_ext, term_ext, sum, max_v, min_v;
  logic signed [FB-1:0] sat;

  always_comb begin
    oi_ext   = SW'(m2_oi_r);
    term_ext = $signed(SW'(m2_term_r));
    sum      = m2_neg_r ? oi_ext - term_ext : oi_ext + term_ext;
    max_v    = SW'({1'b0, {(FB-1){1'b1}}});
    min_v    = -max_v - SW'(1);
    if (sum > max_v) begin
      sat = {1'b0, {(FB-1){1'b1}}};
    end else if (sum < min_v) begin
      sat = {1'b1, {(FB-1){1'b0}}};
    end else begin
      sat = sum[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= sat;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.ez_edge = out_data_r;

endmodule
